@@ hw/rtl/bho_pkg.sv @@
package bho_pkg;

	localparam int NUM_BUCKETS_DEF = 1024;
	localparam int SPILL_DEPTH_DEF = 64;
	localparam int SLOTS_MAX = 8;
	localparam int SLOT_AW = 3;
	localparam int BUCKET_W = 10;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 2;

	localparam logic [63:0] ALL64 = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] LOW32 = 64'h0000_0000_ffff_ffff;

	// operations
	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_SET = 2'd1;
	localparam logic [1:0] OP_UNSET = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	// bucket states
	localparam logic [1:0] BS_UNUSED = 2'd0;
	localparam logic [1:0] BS_SLOTS = 2'd1;
	localparam logic [1:0] BS_OVFL = 2'd2;

	// key modes
	localparam logic [1:0] KM_4B = 2'd0;
	localparam logic [1:0] KM_8B = 2'd1;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_KEY_MODE = 2'd0;
	localparam logic [CFG_IW-1:0] REG_VALUE_WIDE = 2'd1;

	typedef struct packed {
		logic [1:0] op;
		logic [BUCKET_W-1:0] bucket;
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [63:0] new_value;
	} in_t;

	typedef struct packed {
		logic [63:0] found_value;
		logic hit;
		logic status;
		logic [13:0] item_total;
		logic [6:0] overflow_items;
		logic [10:0] spilled_buckets;
	} out_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_MOD, ST_BRD, ST_BST, ST_SSCAN, ST_SDEC, ST_INIT,
		ST_OSCAN, ST_ODEC, ST_NRD, ST_NLD, ST_NSCAN, ST_NACC, ST_NCHK,
		ST_PRD, ST_PLD, ST_PSCAN, ST_PACT, ST_DONE
	} st_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic mod_step;
		logic sscan_start;
		logic spill_start;
		logic spill_item;
		logic sdec;
		logic init_step;
		logic odec;
		logic nacc;
		logic nchk;
		logic pact;
		logic done_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_skip;
		logic mod_last;
		logic [1:0] bst;
		logic op_set;
		logic sscan_busy;
		logic spill_busy;
		logic need_spill;
		logic init_last;
		logic j_last;
		logic need_fail;
		logic out_free;
	} sts_t;

endpackage

@@ hw/rtl/bho_ram.sv @@
module bho_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/bho_ctrl.sv @@
module bho_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bho_pkg::sts_t sts,
	output bho_pkg::cmd_t cmd
);
	import bho_pkg::*;

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = sts.mod_skip ? ST_BRD : ST_MOD;
			ST_MOD: if (sts.mod_last) state_d = ST_BRD;
			ST_BRD: state_d = ST_BST;
			ST_BST: begin
				case (sts.bst)
					BS_OVFL: state_d = ST_OSCAN;
					BS_SLOTS: state_d = ST_SSCAN;
					default: state_d = sts.op_set ? ST_INIT : ST_DONE;
				endcase
			end
			ST_SSCAN: if (!sts.sscan_busy) state_d = ST_SDEC;
			ST_SDEC: state_d = sts.need_spill ? ST_NRD : ST_DONE;
			ST_INIT: if (sts.init_last) state_d = ST_DONE;
			ST_OSCAN: if (!sts.spill_busy) state_d = ST_ODEC;
			ST_ODEC: state_d = ST_DONE;
			ST_NRD: state_d = ST_NLD;
			ST_NLD: state_d = ST_NSCAN;
			ST_NSCAN: if (!sts.spill_busy) state_d = ST_NACC;
			ST_NACC: state_d = sts.j_last ? ST_NCHK : ST_NRD;
			ST_NCHK: state_d = sts.need_fail ? ST_DONE : ST_PRD;
			ST_PRD: state_d = ST_PLD;
			ST_PLD: state_d = ST_PSCAN;
			ST_PSCAN: if (!sts.spill_busy) state_d = ST_PACT;
			ST_PACT: state_d = sts.j_last ? ST_DONE : ST_PRD;
			ST_DONE: if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: cmd.accept = in_valid;
			ST_MOD: cmd.mod_step = 1'b1;
			ST_BST: begin
				cmd.sscan_start = (sts.bst == BS_SLOTS);
				cmd.spill_start = (sts.bst == BS_OVFL);
				cmd.spill_item = 1'b1;
			end
			ST_SDEC: cmd.sdec = 1'b1;
			ST_INIT: cmd.init_step = 1'b1;
			ST_ODEC: cmd.odec = 1'b1;
			ST_NLD: cmd.spill_start = 1'b1;
			ST_NACC: cmd.nacc = 1'b1;
			ST_NCHK: cmd.nchk = 1'b1;
			ST_PLD: cmd.spill_start = 1'b1;
			ST_PACT: cmd.pact = 1'b1;
			ST_DONE: cmd.done_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/bho_dp.sv @@
module bho_dp #(
	parameter int NUM_BUCKETS = 1024,
	parameter int SPILL_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input bho_pkg::cmd_t cmd,
	output bho_pkg::sts_t sts,
	input bho_pkg::in_t in_data,
	input logic cfg_valid,
	input logic [bho_pkg::CFG_IW-1:0] cfg_index,
	input logic [bho_pkg::CFG_DW-1:0] cfg_data,
	output logic out_valid,
	input logic out_stall,
	output bho_pkg::out_t out_data
);
	import bho_pkg::*;

	localparam int BKT_AW = $clog2(NUM_BUCKETS);
	localparam int SLOT_D = NUM_BUCKETS * SLOTS_MAX;
	localparam int SL_AW = BKT_AW + SLOT_AW;
	localparam int SP_AW = $clog2(SPILL_DEPTH);
	localparam int SCW = $clog2(SPILL_DEPTH + 1);
	localparam int SBW = $clog2(NUM_BUCKETS + 1);
	localparam int STW = $clog2(NUM_BUCKETS * SLOTS_MAX + SPILL_DEPTH + 1);
	localparam bit MOD_SKIP = (NUM_BUCKETS >= (1 << BUCKET_W));
	// reciprocal for an exact quotient of any BUCKET_W-bit index
	localparam int MOD_SH = BUCKET_W + $clog2(NUM_BUCKETS);
	localparam int RECIP = ((1 << MOD_SH) + NUM_BUCKETS - 1) / NUM_BUCKETS;

	function automatic logic f_empty(input logic [63:0] v, input logic [63:0] vm);
		f_empty = ((v & vm) == vm);
	endfunction

	function automatic logic f_keq(input logic [63:0] al, input logic [63:0] ah,
			input logic [63:0] bl, input logic [63:0] bh, input logic [63:0] km,
			input logic m2);
		f_keq = (((al ^ bl) & km) == 64'd0) && (!m2 || (ah == bh));
	endfunction

	// configuration
	logic [1:0] km_q;
	logic vw_q;
	logic m0, m2, wide;
	logic [3:0] nslots;
	logic [63:0] kmask, vmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			km_q <= KM_4B;
			vw_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_MODE: km_q <= cfg_data[1:0];
				REG_VALUE_WIDE: vw_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		m0 = (km_q == KM_4B);
		m2 = km_q[1];
		wide = (km_q == KM_8B) && vw_q;
		nslots = m0 ? 4'd8 : (m2 ? 4'd3 : (wide ? 4'd4 : 4'd5));
		kmask = m0 ? LOW32 : ALL64;
		vmask = wide ? ALL64 : LOW32;
	end

	// item registers
	logic [1:0] op_q;
	logic [BUCKET_W-1:0] rem_q;
	logic [BUCKET_W-1:0] quo_q;
	logic [3:0] mk_q;
	logic [63:0] kl_q, kh_q, nv_q;
	logic [BKT_AW-1:0] bidx;
	logic [1:0] op_n;
	logic [63:0] nv_n;
	logic [31:0] mod_prod;

	assign bidx = BKT_AW'(rem_q);
	assign mod_prod = 32'(rem_q) * 32'(RECIP);

	always_comb begin
		nv_n = in_data.new_value & vmask;
		op_n = (in_data.op == OP_RSVD) ? OP_GET : in_data.op;
		if (op_n == OP_SET && f_empty(nv_n, vmask)) begin
			op_n = OP_UNSET;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op_n;
			rem_q <= in_data.bucket;
			mk_q <= 4'd1;
			kl_q <= in_data.key_low & kmask;
			kh_q <= m2 ? in_data.key_high : 64'd0;
			nv_q <= nv_n;
		end else if (cmd.mod_step) begin
			if (mk_q != 4'd0) begin
				quo_q <= BUCKET_W'(mod_prod >> MOD_SH);
			end else begin
				rem_q <= rem_q - BUCKET_W'(32'(quo_q) * 32'(NUM_BUCKETS));
			end
			mk_q <= mk_q - 4'd1;
		end
	end

	// memories
	logic bw_en;
	logic [BKT_AW-1:0] bw_addr;
	logic [1:0] bw_data, bst_rd;
	logic sk_we, sv_we, pk_we, pv_we;
	logic [SL_AW-1:0] s_waddr, s_raddr;
	logic [127:0] sk_wd, sk_rd, pk_wd, pk_rd;
	logic [63:0] sv_wd, sv_rd, pv_wd, pv_rd;
	logic [SP_AW-1:0] p_waddr;

	// slot scan
	logic s_busy_q, sp_q, m_ok_q, fr_ok_q;
	logic [3:0] si_q;
	logic [SLOT_AW-1:0] spidx_q, m_idx_q, fr_idx_q;
	logic [63:0] mval_q;

	// spill scan
	logic p_busy_q, pp_q, fnd_q, sfr_ok_q;
	logic [SP_AW:0] pi_q;
	logic [SP_AW-1:0] ppidx_q, fidx_q, sfr_idx_q;
	logic [63:0] fval_q, lk_l_q, lk_h_q, lk_v_q;
	logic [SPILL_DEPTH-1:0] pvld_q;

	// sequencing and counts
	logic [BKT_AW-1:0] clr_q;
	logic [3:0] j_q, need_q;
	logic [STW-1:0] stored_q;
	logic [SCW-1:0] spc_q;
	logic [SBW-1:0] spb_q;
	logic [63:0] found_q;
	logic hit_q, status_q;

	logic s_hit, need_spill, j_last, use_item;
	logic st_inc, st_dec, pc_inc, pc_dec, pb_inc, vset, vclr, put_new;

	assign s_raddr = {bidx, (s_busy_q ? si_q[SLOT_AW-1:0] : j_q[SLOT_AW-1:0])};

	bho_ram #(.WIDTH(2), .DEPTH(NUM_BUCKETS)) u_bst (
		.clk(clk), .we(bw_en), .waddr(bw_addr), .wdata(bw_data),
		.raddr(bidx), .rdata(bst_rd)
	);
	bho_ram #(.WIDTH(128), .DEPTH(SLOT_D)) u_skey (
		.clk(clk), .we(sk_we), .waddr(s_waddr), .wdata(sk_wd),
		.raddr(s_raddr), .rdata(sk_rd)
	);
	bho_ram #(.WIDTH(64), .DEPTH(SLOT_D)) u_sval (
		.clk(clk), .we(sv_we), .waddr(s_waddr), .wdata(sv_wd),
		.raddr(s_raddr), .rdata(sv_rd)
	);
	bho_ram #(.WIDTH(128), .DEPTH(SPILL_DEPTH)) u_pkey (
		.clk(clk), .we(pk_we), .waddr(p_waddr), .wdata(pk_wd),
		.raddr(pi_q[SP_AW-1:0]), .rdata(pk_rd)
	);
	bho_ram #(.WIDTH(64), .DEPTH(SPILL_DEPTH)) u_pval (
		.clk(clk), .we(pv_we), .waddr(p_waddr), .wdata(pv_wd),
		.raddr(pi_q[SP_AW-1:0]), .rdata(pv_rd)
	);

	always_comb begin
		s_hit = m_ok_q && !f_empty(mval_q, vmask);
		need_spill = (op_q == OP_SET) && !m_ok_q && !fr_ok_q;
		j_last = (j_q == nslots);
		use_item = cmd.spill_item || j_last;
	end

	// write ports and count updates
	always_comb begin
		bw_en = 1'b0;
		bw_addr = bidx;
		bw_data = BS_UNUSED;
		sk_we = 1'b0;
		sv_we = 1'b0;
		s_waddr = {bidx, j_q[SLOT_AW-1:0]};
		sk_wd = {kh_q, kl_q};
		sv_wd = nv_q;
		pk_we = 1'b0;
		pv_we = 1'b0;
		p_waddr = fnd_q ? fidx_q : sfr_idx_q;
		pk_wd = {lk_h_q, lk_l_q};
		pv_wd = lk_v_q;
		st_inc = 1'b0;
		st_dec = 1'b0;
		pc_inc = 1'b0;
		pc_dec = 1'b0;
		pb_inc = 1'b0;
		vset = 1'b0;
		vclr = 1'b0;
		put_new = 1'b0;
		if (cmd.clr_step) begin
			bw_en = 1'b1;
			bw_addr = clr_q;
		end
		if (cmd.init_step) begin
			sk_we = 1'b1;
			sv_we = 1'b1;
			if (j_q != 4'd0) begin
				sk_wd = {ALL64, ALL64};
				sv_wd = ALL64;
			end
			if (sts.init_last) begin
				bw_en = 1'b1;
				bw_data = BS_SLOTS;
				st_inc = 1'b1;
			end
		end
		if (cmd.sdec && !need_spill) begin
			if (op_q == OP_SET) begin
				if (m_ok_q) begin
					s_waddr = {bidx, m_idx_q};
					sv_we = 1'b1;
					st_inc = !s_hit;
				end else begin
					s_waddr = {bidx, fr_idx_q};
					sk_we = 1'b1;
					sv_we = 1'b1;
					st_inc = 1'b1;
				end
			end else if (op_q == OP_UNSET && s_hit) begin
				s_waddr = {bidx, m_idx_q};
				sv_we = 1'b1;
				sv_wd = ALL64;
				st_dec = 1'b1;
			end
		end
		if (cmd.odec) begin
			if (op_q == OP_SET) begin
				if (fnd_q) begin
					pv_we = 1'b1;
				end else if (sfr_ok_q) begin
					pk_we = 1'b1;
					pv_we = 1'b1;
					vset = 1'b1;
					pc_inc = 1'b1;
					st_inc = 1'b1;
				end
			end else if (op_q == OP_UNSET && fnd_q) begin
				vclr = 1'b1;
				pc_dec = 1'b1;
				st_dec = 1'b1;
			end
		end
		if (cmd.pact) begin
			if (fnd_q) begin
				pv_we = 1'b1;
			end else if (sfr_ok_q) begin
				pk_we = 1'b1;
				pv_we = 1'b1;
				vset = 1'b1;
				pc_inc = 1'b1;
				put_new = 1'b1;
			end
			if (!j_last) begin
				st_dec = !put_new;
			end else begin
				st_inc = put_new;
				bw_en = 1'b1;
				bw_data = BS_OVFL;
				pb_inc = 1'b1;
			end
		end
	end

	// slot scan, last match wins, first free kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_busy_q <= 1'b0;
			sp_q <= 1'b0;
			si_q <= 4'd0;
			m_ok_q <= 1'b0;
			fr_ok_q <= 1'b0;
		end else if (cmd.sscan_start) begin
			s_busy_q <= 1'b1;
			sp_q <= 1'b0;
			si_q <= 4'd0;
			m_ok_q <= 1'b0;
			fr_ok_q <= 1'b0;
		end else if (s_busy_q) begin
			sp_q <= (si_q < nslots);
			if (si_q < nslots) begin
				si_q <= si_q + 4'd1;
			end
			if (sp_q) begin
				if (f_keq(sk_rd[63:0], sk_rd[127:64], kl_q, kh_q, kmask, m2)) begin
					m_ok_q <= 1'b1;
				end
				if (f_empty(sv_rd, vmask)) begin
					fr_ok_q <= 1'b1;
				end
				if ({1'b0, spidx_q} == nslots - 4'd1) begin
					s_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_busy_q) begin
			spidx_q <= si_q[SLOT_AW-1:0];
			if (sp_q && f_keq(sk_rd[63:0], sk_rd[127:64], kl_q, kh_q, kmask, m2)) begin
				m_idx_q <= spidx_q;
				mval_q <= sv_rd;
			end
			if (sp_q && f_empty(sv_rd, vmask) && !fr_ok_q) begin
				fr_idx_q <= spidx_q;
			end
		end
	end

	// overflow table scan, first valid match and first free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_busy_q <= 1'b0;
			pp_q <= 1'b0;
			pi_q <= '0;
			fnd_q <= 1'b0;
			sfr_ok_q <= 1'b0;
		end else if (cmd.spill_start) begin
			p_busy_q <= 1'b1;
			pp_q <= 1'b0;
			pi_q <= '0;
			fnd_q <= 1'b0;
			sfr_ok_q <= 1'b0;
		end else if (p_busy_q) begin
			pp_q <= (pi_q < (SP_AW+1)'(SPILL_DEPTH));
			if (pi_q < (SP_AW+1)'(SPILL_DEPTH)) begin
				pi_q <= pi_q + 1'b1;
			end
			if (pp_q) begin
				if (pvld_q[ppidx_q]
						&& f_keq(pk_rd[63:0], pk_rd[127:64], lk_l_q, lk_h_q, kmask, m2)) begin
					fnd_q <= 1'b1;
				end
				if (!pvld_q[ppidx_q]) begin
					sfr_ok_q <= 1'b1;
				end
				if (ppidx_q == SP_AW'(SPILL_DEPTH - 1)) begin
					p_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.spill_start) begin
			if (use_item) begin
				lk_l_q <= kl_q;
				lk_h_q <= kh_q;
				lk_v_q <= nv_q;
			end else begin
				lk_l_q <= sk_rd[63:0] & kmask;
				lk_h_q <= m2 ? sk_rd[127:64] : 64'd0;
				lk_v_q <= sv_rd & vmask;
			end
		end else if (p_busy_q) begin
			ppidx_q <= pi_q[SP_AW-1:0];
			if (pp_q && pvld_q[ppidx_q] && !fnd_q
					&& f_keq(pk_rd[63:0], pk_rd[127:64], lk_l_q, lk_h_q, kmask, m2)) begin
				fidx_q <= ppidx_q;
				fval_q <= pv_rd;
			end
			if (pp_q && !pvld_q[ppidx_q] && !sfr_ok_q) begin
				sfr_idx_q <= ppidx_q;
			end
		end
	end

	// valid bits, counters, result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= '0;
			clr_q <= '0;
			j_q <= 4'd0;
			need_q <= 4'd0;
			stored_q <= '0;
			spc_q <= '0;
			spb_q <= '0;
			found_q <= ALL64;
			hit_q <= 1'b0;
			status_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (vset) begin
				pvld_q[sfr_idx_q] <= 1'b1;
			end
			if (vclr) begin
				pvld_q[fidx_q] <= 1'b0;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept || cmd.sdec || cmd.nchk) begin
				j_q <= 4'd0;
			end else if (cmd.init_step || cmd.nacc || cmd.pact) begin
				j_q <= j_q + 4'd1;
			end
			if (cmd.accept || cmd.sdec) begin
				need_q <= 4'd0;
			end else if (cmd.nacc && !fnd_q) begin
				need_q <= need_q + 4'd1;
			end
			if (st_inc) begin
				stored_q <= stored_q + 1'b1;
			end else if (st_dec && stored_q != '0) begin
				stored_q <= stored_q - 1'b1;
			end
			if (pc_inc) begin
				spc_q <= spc_q + 1'b1;
			end else if (pc_dec && spc_q != '0) begin
				spc_q <= spc_q - 1'b1;
			end
			if (pb_inc) begin
				spb_q <= spb_q + 1'b1;
			end
			if (cmd.accept) begin
				found_q <= ALL64;
				hit_q <= 1'b0;
				status_q <= 1'b0;
			end else if (cmd.sdec) begin
				found_q <= s_hit ? (mval_q & vmask) : ALL64;
				hit_q <= s_hit;
			end else if (cmd.odec) begin
				found_q <= fnd_q ? fval_q : ALL64;
				hit_q <= fnd_q;
				status_q <= (op_q == OP_SET) && !fnd_q && !sfr_ok_q;
			end else if (cmd.nchk && sts.need_fail) begin
				status_q <= 1'b1;
			end
			if (cmd.done_load) begin
				out_valid <= 1'b1;
				out_data.found_value <= found_q;
				out_data.hit <= hit_q;
				out_data.status <= status_q;
				out_data.item_total <= 14'(stored_q);
				out_data.overflow_items <= 7'(spc_q);
				out_data.spilled_buckets <= 11'(spb_q);
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.clr_last = (clr_q == BKT_AW'(NUM_BUCKETS - 1));
		sts.mod_skip = MOD_SKIP;
		sts.mod_last = (mk_q == 4'd0);
		sts.bst = bst_rd;
		sts.op_set = (op_q == OP_SET);
		sts.sscan_busy = s_busy_q;
		sts.spill_busy = p_busy_q;
		sts.need_spill = need_spill;
		sts.init_last = (j_q == 4'd7);
		sts.j_last = j_last;
		sts.need_fail = (SCW'(need_q) > (SCW'(SPILL_DEPTH) - spc_q));
		sts.out_free = !out_valid || !out_stall;
	end

endmodule

@@ hw/rtl/bucketed_hash_with_overflow_top.sv @@
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    in_data (op, bucket, key, new value)
// out       out  out_valid / out_stall  out_data (found value, hit, status, counts)
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item at a time; a get or set on a slot bucket scans its n slots
// (n = 3..8 slots per bucket, one slot ram read per cycle), after a bucket index
// reduction when NUM_BUCKETS is below 1024
// an overflow bucket scans the whole overflow table
// a spill runs one pass of n + 1 table scans, and a second when the table has room
// after reset a clearing pass writes every entry of the bucket state ram
// a waiting result does not hold off the next transfer in; only a new result does
module bucketed_hash_with_overflow_top #(
	parameter int NUM_BUCKETS = bho_pkg::NUM_BUCKETS_DEF,
	parameter int SPILL_DEPTH = bho_pkg::SPILL_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bho_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output bho_pkg::out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bho_pkg::CFG_IW-1:0] cfg_index,
	input logic [bho_pkg::CFG_DW-1:0] cfg_data
);
	import bho_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// registers are always writable
	assign cfg_ready = 1'b1;

	// sequencer: clearing pass, bucket lookup, slot scan, overflow scans, spill
	bho_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	// rams, scan units, counters and result register
	bho_dp #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.SPILL_DEPTH(SPILL_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// one item in flight: a transfer in closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after a transfer");

	// the two scan units never run together
	a_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.sscan_busy && sts.spill_busy))
		else $error("slot and overflow scans overlap");

	// a new result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done_load |-> (!out_valid || !out_stall))
		else $error("result register overwritten");

endmodule
